// ===== rtl/fbvm_pkg.sv =====
package fbvm_pkg;

    localparam int unsigned MemWordsDefault   = 32768;
    localparam int unsigned StackDepthDefault = 1024;

    localparam int unsigned AddrW = 15;
    localparam int unsigned WordW = 16;
    localparam int unsigned ValW  = 15;

    localparam logic [15:0] RegBase = 16'd32768;
    localparam logic [15:0] RegLast = 16'd32775;
    localparam logic [14:0] WordMask = 15'h7fff;

    localparam logic [2:0] StOk   = 3'd0;
    localparam logic [2:0] StChar = 3'd1;
    localparam logic [2:0] StHalt = 3'd2;
    localparam logic [2:0] StWait = 3'd3;
    localparam logic [2:0] StErr  = 3'd4;

    localparam logic [1:0] StopRun  = 2'd0;
    localparam logic [1:0] StopHalt = 2'd1;
    localparam logic [1:0] StopErr  = 2'd2;

    localparam logic [15:0] OpHalt = 16'd0;
    localparam logic [15:0] OpSet  = 16'd1;
    localparam logic [15:0] OpPush = 16'd2;
    localparam logic [15:0] OpPop  = 16'd3;
    localparam logic [15:0] OpEq   = 16'd4;
    localparam logic [15:0] OpGt   = 16'd5;
    localparam logic [15:0] OpJmp  = 16'd6;
    localparam logic [15:0] OpJt   = 16'd7;
    localparam logic [15:0] OpJf   = 16'd8;
    localparam logic [15:0] OpAdd  = 16'd9;
    localparam logic [15:0] OpMult = 16'd10;
    localparam logic [15:0] OpMod  = 16'd11;
    localparam logic [15:0] OpAnd  = 16'd12;
    localparam logic [15:0] OpOr   = 16'd13;
    localparam logic [15:0] OpNot  = 16'd14;
    localparam logic [15:0] OpRmem = 16'd15;
    localparam logic [15:0] OpWmem = 16'd16;
    localparam logic [15:0] OpCall = 16'd17;
    localparam logic [15:0] OpRet  = 16'd18;
    localparam logic [15:0] OpOut  = 16'd19;
    localparam logic [15:0] OpIn   = 16'd20;

    typedef struct packed {
        logic       func;
        logic [14:0] load_addr;
        logic [15:0] load_word;
        logic       in_valid;
        logic [7:0] in_char;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  out_char;
        logic [14:0] next_pc;
        logic        in_used;
    } t_out_item;

endpackage

// ===== rtl/fbvm_if.sv =====
interface fbvm_in_if;
    import fbvm_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fbvm_out_if;
    import fbvm_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/fbvm_modu.sv =====
module fbvm_modu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [14:0] i_a,
    input  logic [14:0] i_b,
    output logic        o_done,
    output logic [14:0] o_rem
);
    import fbvm_pkg::*;

    // Restoring remainder, one dividend bit per cycle.
    logic [14:0] r_rem, n_rem;
    logic [14:0] r_a;
    logic [14:0] r_b;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [15:0] w_sh;

    always_comb begin
        w_sh  = {r_rem, r_a[14]};
        n_rem = (w_sh >= {1'b0, r_b}) ? 15'(w_sh - {1'b0, r_b}) : w_sh[14:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd0;
                r_rem  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_a   <= {r_a[13:0], 1'b0};
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd14) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

// ===== rtl/fifteen_bit_stack_vm_core.sv =====
// Fifteen-bit register and stack virtual machine. An item either loads one
// program word (func 0) or executes one instruction (func 1, or only reports
// halt or error once the machine has stopped) and always returns one result
// item with status, output character, next program counter and whether the
// offered input character was used. The block handles one item at a time.
// A load passes through the output state, where the word is written, before
// its result is presented. An instruction fetches each program word it
// occupies from the program memory, one read at a time (address, then
// registered read data), then decodes and executes, reads the stack or the
// rmem data, and commits. Mod with a nonzero divisor and valid operands
// replaces the stack read with the bit-serial remainder unit. The result
// sits in an output register until it is taken, and the block is ready for
// the next item in the cycle after that.
module fifteen_bit_stack_vm_core #(
    parameter int unsigned MEM_WORDS   = fbvm_pkg::MemWordsDefault,
    parameter int unsigned STACK_DEPTH = fbvm_pkg::StackDepthDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    fbvm_in_if.sink    i_item,
    fbvm_out_if.source o_item
);
    import fbvm_pkg::*;

    localparam int unsigned MemAW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int unsigned StkAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_FETCH = 9'b000000010,
        S_WAIT  = 9'b000000100,
        S_EXEC  = 9'b000001000,
        S_MEM   = 9'b000010000,
        S_MODW  = 9'b000100000,
        S_STK   = 9'b001000000,
        S_FIN   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state;

    logic [WordW-1:0] r_mem [MEM_WORDS];
    logic [ValW-1:0]  r_stk [STACK_DEPTH];
    logic [ValW-1:0]  r_regs [8];

    logic [CntW-1:0] r_sp;
    logic [14:0]     r_pc;
    logic [1:0]      r_stop;

    t_in_item   r_in;
    t_out_item  r_out;
    logic       r_ovalid;

    logic [15:0] r_w [4];       // opcode and operand words
    logic [1:0]  r_fidx;        // word being fetched
    logic [1:0]  r_nwords;
    logic [15:0] r_rdata;       // registered memory read data
    logic        r_rd_inrange;
    logic [14:0] r_sdata;       // registered stack read data

    // Memory port
    logic        w_mem_we;
    logic [14:0] w_mem_waddr;
    logic [15:0] w_mem_wdata;
    logic [14:0] w_mem_raddr;

    // Operand resolution
    function automatic logic [14:0] f_val(input logic [15:0] w, input logic [14:0] r [8]);
        f_val = (w < RegBase) ? w[14:0] : r[w[2:0]];
    endfunction

    logic [15:0] w_op;
    logic [14:0] w_a, w_b, w_c;
    logic        w_bad;
    logic [29:0] w_prod;

    assign w_op = r_w[0];
    assign w_a  = f_val(r_w[1], r_regs);
    assign w_b  = f_val(r_w[2], r_regs);
    assign w_c  = f_val(r_w[3], r_regs);
    assign w_prod = w_b * w_c;

    // Number of operand words that follow an opcode.
    function automatic logic [1:0] f_extra(input logic [15:0] op);
        unique case (op)
            OpSet, OpJt, OpJf, OpNot, OpRmem, OpWmem:               f_extra = 2'd2;
            OpPush, OpPop, OpJmp, OpCall, OpOut, OpIn:              f_extra = 2'd1;
            OpEq, OpGt, OpAdd, OpMult, OpMod, OpAnd, OpOr:          f_extra = 2'd3;
            default:                                                f_extra = 2'd0;
        endcase
    endfunction

    function automatic logic f_badw(input logic [15:0] w);
        f_badw = (w > RegLast);
    endfunction

    always_comb begin
        w_bad = 1'b0;
        if (r_nwords >= 2'd1 && f_badw(r_w[1])) w_bad = 1'b1;
        if (r_nwords >= 2'd2 && f_badw(r_w[2])) w_bad = 1'b1;
        if (r_nwords == 2'd3 && f_badw(r_w[3])) w_bad = 1'b1;
    end

    // Remainder unit for mod
    logic        w_mod_start, w_mod_done;
    logic [14:0] w_mod_rem;
    assign w_mod_start = (r_state == S_EXEC) && !w_bad && (w_op == OpMod) && (w_c != 15'd0);

    fbvm_modu u_modu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_mod_start),
        .i_a    (w_b),
        .i_b    (w_c),
        .o_done (w_mod_done),
        .o_rem  (w_mod_rem)
    );

    assign i_item.ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_item.valid = r_ovalid;
    assign o_item.data  = r_out;

    // Memory read address: fetch words, or the rmem operand held until commit
    always_comb begin
        if (r_state == S_EXEC || r_state == S_MEM) w_mem_raddr = w_b;
        else                                       w_mem_raddr = 15'(r_pc + 15'(r_fidx));
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we && ({1'b0, w_mem_waddr} < 16'(MEM_WORDS)))
            r_mem[w_mem_waddr[MemAW-1:0]] <= w_mem_wdata;
        r_rdata      <= r_mem[w_mem_raddr[MemAW-1:0]];
        r_rd_inrange <= ({1'b0, w_mem_raddr} < 16'(MEM_WORDS));
    end

    // Stack memory: top read registered
    logic [CntW-1:0] w_top;
    assign w_top = r_sp - CntW'(1);
    logic            w_push;
    logic [14:0]     w_push_val;
    always_ff @(posedge i_clk) begin
        if (w_push) r_stk[r_sp[StkAW-1:0]] <= w_push_val;
        r_sdata <= r_stk[w_top[StkAW-1:0]];
    end

    // Execution decision made in S_FIN, with all data ready.
    logic [2:0]  n_status;
    logic [7:0]  n_char;
    logic        n_used;
    logic        n_bad, n_wait, n_halt;
    logic        n_wreg;
    logic [14:0] n_val;
    logic [14:0] n_next;
    logic        n_memw;
    logic        n_pop;

    always_comb begin
        n_status = StOk;
        n_char = '0;
        n_used = 1'b0;
        n_bad = w_bad;
        n_wait = 1'b0;
        n_halt = 1'b0;
        n_wreg = 1'b0;
        n_val = '0;
        n_next = 15'(r_pc + 15'd1);
        n_memw = 1'b0;
        w_push = 1'b0;
        w_push_val = '0;
        n_pop = 1'b0;
        unique case (w_op)
            OpHalt: begin
                n_halt = 1'b1;
                n_next = r_pc;
            end
            OpSet: begin
                n_wreg = 1'b1; n_val = w_b; n_next = 15'(r_pc + 15'd3);
            end
            OpPush: begin
                w_push = 1'b1; w_push_val = w_a; n_next = 15'(r_pc + 15'd2);
            end
            OpPop: begin
                n_wreg = 1'b1; n_pop = 1'b1; n_val = r_sdata; n_next = 15'(r_pc + 15'd2);
                if (r_sp == '0) n_bad = 1'b1;
            end
            OpEq, OpGt, OpAdd, OpMult, OpMod, OpAnd, OpOr: begin
                n_wreg = 1'b1; n_next = 15'(r_pc + 15'd4);
                priority if (w_op == OpEq)  n_val = {14'd0, w_b == w_c};
                else if (w_op == OpGt)      n_val = {14'd0, w_b > w_c};
                else if (w_op == OpAdd)     n_val = 15'(w_b + w_c);
                else if (w_op == OpMult)    n_val = w_prod[14:0];
                else if (w_op == OpMod) begin
                    n_val = w_mod_rem;
                    if (w_c == 15'd0) n_bad = 1'b1;
                end
                else if (w_op == OpAnd)     n_val = w_b & w_c;
                else                        n_val = w_b | w_c;
            end
            OpJmp: n_next = w_a;
            OpJt:  n_next = (w_a != 15'd0) ? w_b : 15'(r_pc + 15'd3);
            OpJf:  n_next = (w_a == 15'd0) ? w_b : 15'(r_pc + 15'd3);
            OpNot: begin
                n_wreg = 1'b1; n_val = ~w_b; n_next = 15'(r_pc + 15'd3);
            end
            OpRmem: begin
                n_wreg = 1'b1; n_next = 15'(r_pc + 15'd3);
                n_val = r_rd_inrange ? r_rdata[14:0] : 15'd0;
            end
            OpWmem: begin
                n_memw = 1'b1; n_next = 15'(r_pc + 15'd3);
            end
            OpCall: begin
                w_push = 1'b1; w_push_val = 15'(r_pc + 15'd2); n_next = w_a;
            end
            OpRet: begin
                n_pop = 1'b1; n_next = r_sdata;
                if (r_sp == '0) n_bad = 1'b1;
            end
            OpOut: begin
                n_status = StChar; n_char = w_a[7:0]; n_next = 15'(r_pc + 15'd2);
            end
            OpIn: begin
                n_wreg = 1'b1; n_next = 15'(r_pc + 15'd2);
                if (!r_in.in_valid) n_wait = 1'b1;
                else begin
                    n_val = {7'd0, r_in.in_char};
                    n_used = 1'b1;
                end
            end
            default: ;
        endcase
        if (w_push && r_sp >= CntW'(STACK_DEPTH)) n_bad = 1'b1;
        if (r_state != S_FIN || n_bad || n_wait || n_halt) begin
            w_push = 1'b0;
        end
    end

    // Program memory write: load item or wmem.
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = r_in.load_addr;
        w_mem_wdata = r_in.load_word;
        if (r_state == S_OUT && !r_in.func) begin
            w_mem_we = 1'b1;
        end else if (r_state == S_FIN && n_memw && !n_bad) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = w_a;
            w_mem_wdata = {1'b0, w_b};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_sp     <= '0;
            r_pc     <= '0;
            r_stop   <= StopRun;
            r_fidx   <= '0;
            r_nwords <= '0;
            for (int i = 0; i < 8; i++) r_regs[i] <= '0;
        end else begin
            if (o_item.valid && o_item.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_item.valid && i_item.ready) begin
                        r_in <= i_item.data;
                        r_fidx <= 2'd0;
                        r_nwords <= 2'd0;
                        if (!i_item.data.func || r_stop != StopRun) r_state <= S_OUT;
                        else r_state <= S_FETCH;
                    end
                end
                S_FETCH: r_state <= S_WAIT;
                S_WAIT: begin
                    r_w[r_fidx] <= r_rd_inrange ? r_rdata : 16'd0;
                    if (r_fidx == 2'd0) r_nwords <= f_extra(r_rd_inrange ? r_rdata : 16'd0);
                    if ((r_fidx == 2'd0 && f_extra(r_rd_inrange ? r_rdata : 16'd0) == 2'd0)
                        || (r_fidx != 2'd0 && r_fidx == r_nwords)) begin
                        r_state <= S_EXEC;
                    end else begin
                        r_fidx  <= r_fidx + 2'd1;
                        r_state <= S_FETCH;
                    end
                end
                S_EXEC: begin
                    if (w_mod_start) r_state <= S_MODW;
                    else if (w_op == OpRmem) r_state <= S_MEM;
                    else r_state <= S_STK;
                end
                S_MEM:  r_state <= S_FIN;
                S_MODW: if (w_mod_done) r_state <= S_FIN;
                S_STK:  r_state <= S_FIN;
                S_FIN: begin
                    r_out.status   <= n_bad ? StErr : (n_wait ? StWait :
                                      (n_halt ? StHalt : n_status));
                    r_out.out_char <= n_bad ? 8'd0 : n_char;
                    r_out.in_used  <= n_bad ? 1'b0 : n_used;
                    r_out.next_pc  <= (n_bad || n_wait || n_halt) ? r_pc : n_next;
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                    if (n_bad) r_stop <= StopErr;
                    else if (n_halt) r_stop <= StopHalt;
                    else if (!n_wait) begin
                        if (n_wreg && r_w[1] >= RegBase) r_regs[r_w[1][2:0]] <= n_val;
                        if (w_push) r_sp <= r_sp + CntW'(1);
                        else if (n_pop) r_sp <= r_sp - CntW'(1);
                        r_pc <= n_next;
                    end
                end
                S_OUT: begin
                    r_out.status   <= (!r_in.func) ? StOk :
                                      ((r_stop == StopHalt) ? StHalt : StErr);
                    r_out.out_char <= '0;
                    r_out.in_used  <= 1'b0;
                    r_out.next_pc  <= r_pc;
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== tb/sv/fbvm_result_checker.sv =====
// Watches both channels of the VM core. It keeps its own copy of the
// machine state, works out the expected result of every accepted item and
// compares each accepted result with the oldest expectation.
module fbvm_result_checker
    import fbvm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    fbvm_in_if         i_item,
    fbvm_out_if        i_result,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int unsigned StackSize = StackDepthDefault;

    logic [15:0] vm_mem [0:MemWordsDefault-1];
    logic [14:0] vm_regs [0:7];
    logic [14:0] vm_stack [0:StackSize-1];
    int unsigned vm_depth;
    logic [14:0] vm_pc;
    logic [1:0]  vm_stop;

    t_out_item expected_q [$];

    assign o_pending = expected_q.size();

    function automatic logic [15:0] fetch(input int unsigned addr);
        return vm_mem[addr & 32'h7fff];
    endfunction

    // Literal or register contents; flags words past the register range.
    function automatic int unsigned src_value(input logic [15:0] w, inout logic bad);
        if (w < RegBase) return w;
        if (w <= RegLast) return vm_regs[w[2:0]];
        bad = 1'b1;
        return 0;
    endfunction

    // Register index to write, or -1 when the destination is a literal.
    function automatic int dst_index(input logic [15:0] w, inout logic bad);
        if (w < RegBase) return -1;
        if (w <= RegLast) return int'(w[2:0]);
        bad = 1'b1;
        return -1;
    endfunction

    function automatic t_out_item execute_item(input t_in_item it);
        t_out_item   res;
        logic [15:0] op, w1, w2, w3;
        logic        bad, waiting, halting, mem_do;
        int          dst;
        int unsigned val, a, b, pc, next, mem_addr, mem_val, push_val;
        int          stack_op;
        res = '0;
        res.next_pc = vm_pc;
        if (!it.func) begin
            vm_mem[it.load_addr] = it.load_word;
            return res;
        end
        if (vm_stop != StopRun) begin
            res.status = (vm_stop == StopHalt) ? StHalt : StErr;
            return res;
        end
        pc = vm_pc;
        op = fetch(pc);
        w1 = fetch(pc + 1);
        w2 = fetch(pc + 2);
        w3 = fetch(pc + 3);
        bad = 1'b0; waiting = 1'b0; halting = 1'b0; mem_do = 1'b0;
        dst = -1; val = 0; mem_addr = 0; mem_val = 0; push_val = 0;
        stack_op = 0; next = pc + 1; a = 0; b = 0;
        case (op)
            OpHalt: begin
                halting = 1'b1;
                next = pc;
            end
            OpSet: begin
                dst = dst_index(w1, bad);
                val = src_value(w2, bad);
                next = pc + 3;
            end
            OpPush: begin
                push_val = src_value(w1, bad);
                stack_op = 1;
                next = pc + 2;
            end
            OpPop: begin
                dst = dst_index(w1, bad);
                stack_op = 2;
                next = pc + 2;
                if (vm_depth == 0) bad = 1'b1;
                else val = vm_stack[(vm_depth - 1) % StackSize];
            end
            OpEq, OpGt, OpAdd, OpMult, OpMod, OpAnd, OpOr: begin
                dst = dst_index(w1, bad);
                a = src_value(w2, bad);
                b = src_value(w3, bad);
                next = pc + 4;
                case (op)
                    OpEq:   val = (a == b);
                    OpGt:   val = (a > b);
                    OpAdd:  val = a + b;
                    OpMult: val = a * b;
                    OpMod: begin
                        if (b == 0) bad = 1'b1;
                        else val = a % b;
                    end
                    OpAnd:  val = a & b;
                    default: val = a | b;
                endcase
            end
            OpJmp: next = src_value(w1, bad);
            OpJt, OpJf: begin
                a = src_value(w1, bad);
                b = src_value(w2, bad);
                next = ((a != 0) == (op == OpJt)) ? b : pc + 3;
            end
            OpNot: begin
                dst = dst_index(w1, bad);
                val = ~src_value(w2, bad);
                next = pc + 3;
            end
            OpRmem: begin
                dst = dst_index(w1, bad);
                val = fetch(src_value(w2, bad));
                next = pc + 3;
            end
            OpWmem: begin
                mem_addr = src_value(w1, bad);
                mem_val = src_value(w2, bad);
                mem_do = 1'b1;
                next = pc + 3;
            end
            OpCall: begin
                next = src_value(w1, bad);
                push_val = pc + 2;
                stack_op = 1;
            end
            OpRet: begin
                stack_op = 2;
                if (vm_depth == 0) bad = 1'b1;
                else next = vm_stack[(vm_depth - 1) % StackSize];
            end
            OpOut: begin
                res.out_char = 8'(src_value(w1, bad));
                res.status = StChar;
                next = pc + 2;
            end
            OpIn: begin
                dst = dst_index(w1, bad);
                next = pc + 2;
                if (!it.in_valid) begin
                    waiting = 1'b1;
                end else begin
                    val = it.in_char;
                    res.in_used = 1'b1;
                end
            end
            default: ;
        endcase
        if (stack_op == 1 && vm_depth >= StackSize) bad = 1'b1;

        if (bad) begin
            vm_stop = StopErr;
            res.status = StErr;
            res.out_char = '0;
            res.in_used = 1'b0;
        end else if (waiting) begin
            res.status = StWait;
        end else if (halting) begin
            vm_stop = StopHalt;
            res.status = StHalt;
        end else begin
            if (dst >= 0) vm_regs[dst] = val[14:0];
            if (mem_do) vm_mem[mem_addr & 32'h7fff] = {1'b0, mem_val[14:0]};
            if (stack_op == 1) begin
                vm_stack[vm_depth % StackSize] = push_val[14:0];
                vm_depth++;
            end else if (stack_op == 2) begin
                vm_depth--;
            end
            vm_pc = next[14:0];
        end
        res.next_pc = vm_pc;
        return res;
    endfunction

    task automatic report(input string field, input int unsigned want,
                          input int unsigned have);
        $display("mismatch: %s expected %0d got %0d", field, want, have);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item have;
        if (!i_rst_n) begin
            for (int r = 0; r < 8; r++) vm_regs[r] = '0;
            vm_depth = 0;
            vm_pc = '0;
            vm_stop = StopRun;
            expected_q.delete();
        end else begin
            if (i_item.valid && i_item.ready)
                expected_q.push_back(execute_item(i_item.data));
            if (i_result.valid && i_result.ready) begin
                have = i_result.data;
                if (expected_q.size() == 0) begin
                    report("unexpected result, status", 0, have.status);
                end else begin
                    want = expected_q.pop_front();
                    if (have.status !== want.status)
                        report("status", want.status, have.status);
                    if (have.out_char !== want.out_char)
                        report("out_char", want.out_char, have.out_char);
                    if (have.next_pc !== want.next_pc)
                        report("next_pc", want.next_pc, have.next_pc);
                    if (have.in_used !== want.in_used)
                        report("in_used", want.in_used, have.in_used);
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb_fifteen_bit_stack_vm_core.sv =====
// Top of the VM core testbench. It drives items and stalls on both
// channels and gives the verdict; the checker beside the block predicts
// and compares every result.
//
// The machine can only be brought back to a running state by reset, and
// reset happens once, so the whole run is one long program. Every
// instruction is written to the program memory at the current program
// counter before it is first executed, which lets the stimulus choose
// operations freely while following jumps, calls and returns wherever
// they lead. An rmem only ever reads a word that has been written: one of
// its own instruction words, or a word stored by an earlier wmem.
module tb_fifteen_bit_stack_vm_core;
    import fbvm_pkg::*;

    localparam logic [15:0] OpNoop         = 16'd21;
    localparam int unsigned CycleLimit     = 4000000;
    localparam int unsigned RandomOps      = 170;
    localparam int unsigned RandomOpsShort = 40;

    // Ways to end the program: the machine stops for good on any of them.
    typedef enum int {
        EndHalt, EndBadOperand, EndModZero, EndPopEmpty, EndPushFull
    } t_ending;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   n_items;
    int   n_steps;
    int   cycle_count;
    logic idle_on;

    // Software view of where the program is and how deep the stack is.
    logic [14:0] cur_pc;
    int          stack_depth;

    fbvm_in_if  in_ch ();
    fbvm_out_if out_ch ();

    fifteen_bit_stack_vm_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (in_ch.sink),
        .o_item  (out_ch.source)
    );

    fbvm_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (in_ch),
        .i_result     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // One stretch in five runs with no stalls on either side.
    assign idle_on = ((n_items / 150) % 5) != 4;

    always @(negedge i_clk) begin
        out_ch.ready <= idle_on ? ($urandom_range(0, 99) >= 33) : 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [15:0] reg_word(input int unsigned r);
        return RegBase + 16'(r);
    endfunction

    // Half the time a register, otherwise random literals or literal extremes.
    function automatic logic [15:0] rand_src();
        case ($urandom_range(0, 3))
            0, 1: return reg_word($urandom_range(0, 7));
            2: return 16'($urandom_range(0, 32767));
            default: begin
                case ($urandom_range(0, 2))
                    0: return 16'd0;
                    1: return 16'd1;
                    default: return 16'd32767;
                endcase
            end
        endcase
    endfunction

    function automatic logic [15:0] rand_dst();
        if ($urandom_range(0, 99) < 85) return reg_word($urandom_range(0, 7));
        return 16'($urandom_range(0, 32767));
    endfunction

    // Sends one item and waits for its result; the block takes one at a time.
    task automatic xfer(input t_in_item it, output t_out_item got);
        @(negedge i_clk);
        while (idle_on && $urandom_range(0, 99) < 33) @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        got = out_ch.data;
        n_items++;
    endtask

    task automatic load_word(input logic [14:0] addr, input logic [15:0] word);
        t_in_item  it;
        t_out_item got;
        it.func      = 1'b0;
        it.load_addr = addr;
        it.load_word = word;
        it.in_valid  = 1'($urandom_range(0, 1));
        it.in_char   = 8'($urandom_range(0, 255));
        xfer(it, got);
    endtask

    task automatic step(input logic in_valid, input logic [7:0] ch,
                        output t_out_item got);
        t_in_item it;
        it.func      = 1'b1;
        it.load_addr = 15'($urandom_range(0, 32767));
        it.load_word = 16'($urandom_range(0, 65535));
        it.in_valid  = in_valid;
        it.in_char   = ch;
        xfer(it, got);
        n_steps++;
        cur_pc = got.next_pc;
    endtask

    // Writes the instruction at the program counter, runs it and keeps
    // the stack depth in step when it completed.
    task automatic run_op(input logic [15:0] op, input logic [15:0] w1,
                          input logic [15:0] w2, input logic [15:0] w3,
                          input logic in_valid, input logic [7:0] ch);
        t_out_item got;
        load_word(cur_pc, op);
        load_word(cur_pc + 15'd1, w1);
        load_word(cur_pc + 15'd2, w2);
        load_word(cur_pc + 15'd3, w3);
        step(in_valid, ch, got);
        if (got.status == StOk || got.status == StChar) begin
            if (op == OpPush || op == OpCall) stack_depth++;
            if (op == OpPop || op == OpRet) stack_depth--;
        end
    endtask

    task automatic run_simple(input logic [15:0] op, input logic [15:0] w1,
                              input logic [15:0] w2, input logic [15:0] w3);
        run_op(op, w1, w2, w3, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    task automatic run_random_op();
        logic [15:0] op;
        op = 16'($urandom_range(1, 22));
        if (op == 16'd22) op = 16'($urandom_range(22, 65535));
        if ((op == OpPush || op == OpCall) && stack_depth >= StackDepthDefault)
            op = OpPop;
        if ((op == OpPop || op == OpRet) && stack_depth == 0)
            op = OpPush;
        case (op)
            OpSet, OpNot:
                run_simple(op, rand_dst(), rand_src(), rand_src());
            // The address is one of the instruction's own words, which are written.
            OpRmem:
                run_simple(op, rand_dst(),
                           {1'b0, 15'(cur_pc + 15'($urandom_range(0, 3)))},
                           rand_src());
            OpPop:
                run_simple(op, rand_dst(), rand_src(), rand_src());
            OpEq, OpGt, OpAdd, OpMult, OpAnd, OpOr:
                run_simple(op, rand_dst(), rand_src(), rand_src());
            // A register divisor could hold zero, which would stop the run.
            OpMod:
                run_simple(op, rand_dst(), rand_src(), 16'($urandom_range(1, 32767)));
            OpIn:
                run_op(op, rand_dst(), rand_src(), rand_src(),
                       $urandom_range(0, 99) < 70, 8'($urandom_range(0, 255)));
            default:
                run_simple(op, rand_src(), rand_src(), rand_src());
        endcase
    endtask

    initial begin
        t_out_item got;
        t_ending   ending;
        logic [15:0] bad_word;
        int        n_random;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        n_items      = 0;
        n_steps      = 0;
        cycle_count  = 0;
        cur_pc       = '0;
        stack_depth  = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // The machine stops for good, so exactly one way to stop is chosen.
        // Filling the stack is a long run of its own, so fewer random
        // operations go before it.
        ending   = t_ending'($urandom_range(0, 4));
        n_random = (ending == EndPushFull) ? RandomOpsShort : RandomOps;

        // Directed part: every operation but halt, and the corner cases.
        run_simple(OpSet, reg_word(0), 16'd32767, 16'd0);
        run_simple(OpSet, reg_word(1), reg_word(0), 16'd0);
        run_simple(OpAdd, reg_word(2), reg_word(0), reg_word(1));
        run_simple(OpMult, reg_word(3), reg_word(0), 16'd32767);
        run_simple(OpMod, reg_word(4), reg_word(0), 16'd7);
        run_simple(OpEq, reg_word(5), reg_word(0), reg_word(1));
        run_simple(OpGt, reg_word(6), 16'd0, reg_word(0));
        run_simple(OpAnd, reg_word(7), reg_word(0), 16'h2aaa);
        run_simple(OpOr, reg_word(7), reg_word(7), 16'h5555);
        run_simple(OpNot, reg_word(1), 16'd0, 16'd0);
        run_simple(OpPush, reg_word(0), 16'd0, 16'd0);
        run_simple(OpPush, 16'd12345, 16'd0, 16'd0);
        // A literal destination drops the write but still pops.
        run_simple(OpPop, 16'd100, 16'd0, 16'd0);
        run_simple(OpPop, reg_word(3), 16'd0, 16'd0);
        run_simple(OpCall, 16'd500, 16'd0, 16'd0);
        run_simple(OpRet, 16'd0, 16'd0, 16'd0);
        run_simple(OpJt, reg_word(0), 16'd32766, 16'd0);
        // Operand fetches at the top of memory wrap to address zero.
        run_simple(OpOut, reg_word(0), 16'd0, 16'd0);
        run_simple(OpJf, 16'd0, 16'd32767, 16'd0);
        run_simple(OpJf, reg_word(0), 16'd0, 16'd0);
        run_simple(OpWmem, 16'd32767, reg_word(0), 16'd0);
        run_simple(OpRmem, reg_word(2), 16'd32767, 16'd0);
        run_op(OpIn, reg_word(4), 16'd0, 16'd0, 1'b0, 8'h00);
        run_op(OpIn, reg_word(4), 16'd0, 16'd0, 1'b1, 8'hff);
        run_simple(16'd65535, 16'd0, 16'd0, 16'd0);
        run_simple(OpNoop, 16'd0, 16'd0, 16'd0);
        run_simple(OpJmp, 16'd0, 16'd0, 16'd0);

        // Random programs, with a stray load now and then.
        for (int n = 0; n < n_random; n++) begin
            if ($urandom_range(0, 9) == 0)
                load_word(15'($urandom_range(0, 32767)), 16'($urandom_range(0, 65535)));
            run_random_op();
        end

        case (ending)
            EndHalt:
                run_simple(OpHalt, 16'd0, 16'd0, 16'd0);
            EndBadOperand: begin
                bad_word = 16'($urandom_range(32776, 65535));
                run_simple(OpAdd, reg_word(0), bad_word, 16'd1);
            end
            EndModZero:
                run_simple(OpMod, reg_word(0), reg_word(1), 16'd0);
            EndPopEmpty: begin
                while (stack_depth > 0)
                    run_simple(OpPop, rand_dst(), 16'd0, 16'd0);
                run_simple(OpPop, reg_word(0), 16'd0, 16'd0);
            end
            default: begin
                // A call to itself pushes once per step without new loads.
                load_word(cur_pc, OpCall);
                load_word(cur_pc + 15'd1, {1'b0, cur_pc});
                load_word(cur_pc + 15'd2, 16'd0);
                load_word(cur_pc + 15'd3, 16'd0);
                while (stack_depth < StackDepthDefault) begin
                    step(1'b0, 8'h00, got);
                    if (got.status != StOk) break;
                    stack_depth++;
                end
                step(1'b0, 8'h00, got);
            end
        endcase
        // A stopped machine still answers steps and takes loads.
        for (int n = 0; n < 4; n++) begin
            step(1'b1, 8'h41, got);
            load_word(cur_pc, OpNoop);
        end

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Ran %0d items, %0d of them instructions, ending by %s.",
                 n_items, n_steps, ending.name());
        $display("Stack depth before the end was %0d, mismatches %0d.",
                 stack_depth, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== fifteen_bit_stack_vm_core.f =====
rtl/fbvm_pkg.sv
rtl/fbvm_if.sv
rtl/fbvm_modu.sv
rtl/fifteen_bit_stack_vm_core.sv
tb/sv/fbvm_result_checker.sv
tb/sv/tb_fifteen_bit_stack_vm_core.sv
